/* rtl/uvbar_pkg.sv */
// ----------------------------------------------------------------------------
// uvbar_pkg
// shared types, constants and helpers of the uv index bar display unit
// ----------------------------------------------------------------------------
package uvbar_pkg;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;
    localparam int ADDR_W     = 5;
    localparam int PROD_W     = 40;
    localparam int ACC_W      = 41;
    localparam int NEG_W      = 27;
    localparam int CALC_W     = 24;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_UVI = 2'd1,
        MODE_UVA = 2'd2,
        MODE_UVB = 2'd3
    } mode_t;

    localparam logic [1:0] PRESS_NONE  = 2'd0;
    localparam logic [1:0] PRESS_SHORT = 2'd1;

    localparam logic [2:0] REG_UVA_COMP_ONE = 3'd0;
    localparam logic [2:0] REG_UVA_COMP_TWO = 3'd1;
    localparam logic [2:0] REG_UVB_COMP_ONE = 3'd2;
    localparam logic [2:0] REG_UVB_COMP_TWO = 3'd3;
    localparam logic [2:0] REG_UVA_GAIN     = 3'd4;
    localparam logic [2:0] REG_UVB_GAIN     = 3'd5;
    localparam logic [2:0] REG_IDLE_LIMIT   = 3'd6;

    localparam logic [2:0] STEP_A_ONE  = 3'd0;
    localparam logic [2:0] STEP_A_TWO  = 3'd1;
    localparam logic [2:0] STEP_B_ONE  = 3'd2;
    localparam logic [2:0] STEP_B_TWO  = 3'd3;
    localparam logic [2:0] STEP_GAIN_A = 3'd4;
    localparam logic [2:0] STEP_GAIN_B = 3'd5;

    localparam logic [9:0]  RST_UVA_COMP_ONE = 10'd568;
    localparam logic [9:0]  RST_UVA_COMP_TWO = 10'd340;
    localparam logic [9:0]  RST_UVB_COMP_ONE = 10'd755;
    localparam logic [9:0]  RST_UVB_COMP_TWO = 10'd445;
    localparam logic [15:0] RST_UVA_GAIN     = 16'd2231;
    localparam logic [15:0] RST_UVB_GAIN     = 16'd3956;
    localparam logic [7:0]  RST_IDLE_LIMIT   = 8'd150;

    localparam logic [7:0] ROW_A_BASE = 8'hE0;
    localparam logic [7:0] ROW_B_BASE = 8'hD0;
    localparam logic [7:0] IND_BASE   = 8'hB0;
    localparam logic [7:0] LEVEL_MAX  = 8'd254;

    localparam logic [7:0] THR_UPPER_A = 8'd24;
    localparam logic [7:0] THR_UPPER_B = 8'd152;
    localparam logic [7:0] THR_LOWER_A = 8'd8;
    localparam logic [7:0] THR_LOWER_B = 8'd136;

    function automatic logic [3:0] row_bits(input logic [7:0] level,
                                            input logic [7:0] first);
        logic [3:0] bits;
        logic [8:0] thr;
        bits = '0;
        for (int k = 0; k < 4; k++) begin
            thr = {1'b0, first} + 9'(32 * k);
            bits[k] = ({1'b0, level} >= thr);
        end
        return bits;
    endfunction

endpackage

/* rtl/uv_index_bar_display_unit.sv */
// ----------------------------------------------------------------------------
// uv_index_bar_display_unit
// per-pass display mode control, light compensation and bar row coding
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | contents
//  s_       | in  | s_tvalid/s_tready  | one measurement pass
//  m_       | out | m_tvalid/m_tready  | one display result
//  apb      | in  | psel/penable       | seven config registers at 4*i
//
// a pass with the display on, once its request is taken, runs six turns of the
// one shared 24x16 multiplier in ST_CALC, then codes the level in ST_OUT and
// loads the result into the output register; the unit takes no new request meanwhile.
// a pass that ends off goes from ST_IDLE straight to ST_OUT.
// s_tready is high only while the sequencer is idle; a result waiting on
// m_tready holds in the output register and stalls the next pass in ST_OUT.
// aresetn is synchronous, active low; it restores the register defaults.
// ----------------------------------------------------------------------------
module uv_index_bar_display_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // uva_raw, uvb_raw, comp_one_raw, comp_two_raw, press, wake
    input  logic [uvbar_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mode, level, upper_row_a, upper_row_b, lower_row_a, lower_row_b, indicator, sleep
    output logic [uvbar_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uvbar_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import uvbar_pkg::*;

    logic [9:0]  uva_comp_one_reg, uva_comp_two_reg, uvb_comp_one_reg, uvb_comp_two_reg;
    logic [15:0] uva_gain_reg, uvb_gain_reg;
    logic [7:0]  idle_limit_reg;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [7:0]  idle_reg, idle_next, idle_tmp;
    logic [2:0]  step_reg;

    logic [15:0] uva_reg, uvb_reg, c1_reg, c2_reg;
    logic [NEG_W-1:0]  neg_reg;
    logic [CALC_W-1:0] a_calc_reg, b_calc_reg, calc_next;
    logic [ACC_W-1:0]  acc_reg;

    logic [CALC_W-1:0] mul_a;
    logic [15:0]       mul_b;
    logic [PROD_W-1:0] prod;
    logic [CALC_W-1:0] pos;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic        s_fire, cfg_wr, out_load;
    logic [15:0] in_uva, in_uvb, in_c1, in_c2;
    logic [1:0]  in_press;
    logic        in_wake;
    logic [ACC_W-1:0] shifted;
    logic [7:0]  level;
    logic [OUT_DATA_W-1:0] out_word;

    assign in_uva   = s_tdata[15:0];
    assign in_uvb   = s_tdata[31:16];
    assign in_c1    = s_tdata[47:32];
    assign in_c2    = s_tdata[63:48];
    assign in_press = s_tdata[65:64];
    assign in_wake  = s_tdata[66];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uva_comp_one_reg <= RST_UVA_COMP_ONE;
            uva_comp_two_reg <= RST_UVA_COMP_TWO;
            uvb_comp_one_reg <= RST_UVB_COMP_ONE;
            uvb_comp_two_reg <= RST_UVB_COMP_TWO;
            uva_gain_reg     <= RST_UVA_GAIN;
            uvb_gain_reg     <= RST_UVB_GAIN;
            idle_limit_reg   <= RST_IDLE_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_UVA_COMP_ONE: uva_comp_one_reg <= pwdata[9:0];
                REG_UVA_COMP_TWO: uva_comp_two_reg <= pwdata[9:0];
                REG_UVB_COMP_ONE: uvb_comp_one_reg <= pwdata[9:0];
                REG_UVB_COMP_TWO: uvb_comp_two_reg <= pwdata[9:0];
                REG_UVA_GAIN:     uva_gain_reg     <= pwdata[15:0];
                REG_UVB_GAIN:     uvb_gain_reg     <= pwdata[15:0];
                REG_IDLE_LIMIT:   idle_limit_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_UVA_COMP_ONE: prdata = {22'd0, uva_comp_one_reg};
            REG_UVA_COMP_TWO: prdata = {22'd0, uva_comp_two_reg};
            REG_UVB_COMP_ONE: prdata = {22'd0, uvb_comp_one_reg};
            REG_UVB_COMP_TWO: prdata = {22'd0, uvb_comp_two_reg};
            REG_UVA_GAIN:     prdata = {16'd0, uva_gain_reg};
            REG_UVB_GAIN:     prdata = {16'd0, uvb_gain_reg};
            REG_IDLE_LIMIT:   prdata = {24'd0, idle_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // mode and idle timeout, settled when the request is taken
    always_comb begin
        mode_next = mode_reg;
        idle_next = idle_reg;
        idle_tmp  = idle_reg;
        if (mode_reg == MODE_OFF) begin
            if (in_wake) begin
                mode_next = MODE_UVI;
                idle_next = 8'd1;
                if (8'd1 >= idle_limit_reg) begin
                    mode_next = MODE_OFF;
                end
            end
        end else begin
            if (in_press != PRESS_NONE) begin
                idle_tmp = '0;
            end
            if (in_press == PRESS_SHORT) begin
                mode_next = mode_t'(mode_reg + 2'd1);
            end
            if (idle_tmp != 8'hFF) begin
                idle_tmp = idle_tmp + 8'd1;
            end
            idle_next = idle_tmp;
            if (idle_tmp >= idle_limit_reg) begin
                mode_next = MODE_OFF;
            end
        end
        if (mode_next == MODE_OFF) begin
            idle_next = '0;
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (step_reg)
            STEP_A_ONE: begin
                mul_a = {8'd0, c1_reg};
                mul_b = {6'd0, uva_comp_one_reg};
            end
            STEP_A_TWO: begin
                mul_a = {8'd0, c2_reg};
                mul_b = {6'd0, uva_comp_two_reg};
            end
            STEP_B_ONE: begin
                mul_a = {8'd0, c1_reg};
                mul_b = {6'd0, uvb_comp_one_reg};
            end
            STEP_B_TWO: begin
                mul_a = {8'd0, c2_reg};
                mul_b = {6'd0, uvb_comp_two_reg};
            end
            STEP_GAIN_A: begin
                mul_a = a_calc_reg;
                mul_b = uva_gain_reg;
            end
            STEP_GAIN_B: begin
                mul_a = b_calc_reg;
                mul_b = uvb_gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // clamp of the channel after its second weight, a at STEP_B_ONE, b at STEP_GAIN_A
    assign pos = (step_reg == STEP_B_ONE) ? {uva_reg, 8'd0} : {uvb_reg, 8'd0};
    assign calc_next = ({3'd0, pos} > neg_reg) ? (pos - neg_reg[CALC_W-1:0]) : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = (mode_next == MODE_OFF) ? ST_OUT : ST_CALC;
            ST_CALC: if (step_reg == STEP_GAIN_B) state_next = ST_OUT;
            ST_OUT:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_OFF;
            idle_reg     <= '0;
            step_reg     <= STEP_A_ONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                mode_reg <= mode_next;
                idle_reg <= idle_next;
                step_reg <= STEP_A_ONE;
            end else if (state_reg == ST_CALC) begin
                step_reg <= step_reg + 3'd1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            uva_reg <= in_uva;
            uvb_reg <= in_uvb;
            c1_reg  <= in_c1;
            c2_reg  <= in_c2;
        end
        if (state_reg == ST_CALC) begin
            priority case (step_reg)
                STEP_A_ONE: neg_reg <= prod[NEG_W-1:0];
                STEP_A_TWO: neg_reg <= neg_reg + prod[NEG_W-1:0];
                STEP_B_ONE: begin
                    a_calc_reg <= calc_next;
                    neg_reg    <= prod[NEG_W-1:0];
                end
                STEP_B_TWO: neg_reg <= neg_reg + prod[NEG_W-1:0];
                STEP_GAIN_A: begin
                    b_calc_reg <= calc_next;
                    acc_reg    <= (mode_reg != MODE_UVB) ? {1'b0, prod} : '0;
                end
                STEP_GAIN_B: begin
                    if (mode_reg != MODE_UVA) begin
                        acc_reg <= acc_reg + {1'b0, prod};
                    end
                end
                default: ;
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    // level and bar coding
    assign shifted = (mode_reg == MODE_UVI) ? (acc_reg >> 25) : (acc_reg >> 24);
    assign level   = (shifted > ACC_W'(LEVEL_MAX)) ? LEVEL_MAX : shifted[7:0];

    always_comb begin
        out_word = '0;
        out_word[1:0] = mode_reg;
        if (mode_reg == MODE_OFF) begin
            out_word[50] = 1'b1;
        end else begin
            out_word[9:2]   = level;
            out_word[17:10] = ROW_A_BASE | {4'd0, row_bits(level, THR_UPPER_A)};
            out_word[25:18] = ROW_B_BASE | {4'd0, row_bits(level, THR_UPPER_B)};
            out_word[33:26] = ROW_A_BASE | {4'd0, row_bits(level, THR_LOWER_A)};
            out_word[41:34] = ROW_B_BASE | {4'd0, row_bits(level, THR_LOWER_B)};
            out_word[49:42] = IND_BASE | (8'd1 << (mode_reg - 2'd1));
        end
    end

    // off state always leaves the idle counter cleared
    a_idle_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OFF) |-> (idle_reg == 8'd0))
        else $error("idle count nonzero while off");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("request taken while a pass is in work");

    a_sleep_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[50] == (m_tdata_reg[1:0] == MODE_OFF)))
        else $error("sleep flag disagrees with mode");

    a_off_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[1:0] == MODE_OFF) |->
        (m_tdata_reg[49:2] == '0))
        else $error("display not blank while off");

    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[9:2] <= LEVEL_MAX))
        else $error("level above saturation");

endmodule

/* sim/uv_index_bar_display_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_index_bar_display_unit_tb
// self-checking bench for the uv index bar display unit
//
// measurement passes are queued by the stimulus process and offered on the
// s_ stream by a clocked driver. A software copy of the mode control and the
// compensation math predicts each display result when its request is taken.
// A clocked monitor compares every m_ result with the oldest prediction.
// Registers are rewritten over apb between phases, only while the unit is
// idle. Sender and receiver gaps vary from phase to phase, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module uv_index_bar_display_unit_tb;

    import uvbar_pkg::*;

    localparam logic [1:0] PRESS_LONG  = 2'd2;
    localparam logic [1:0] PRESS_THREE = 2'd3;
    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic        wake;
        logic [1:0]  press;
        logic [15:0] comp_two, comp_one, uvb, uva;
    } pass_t;

    typedef struct packed {
        logic       sleep;
        logic [7:0] indicator, lower_b, lower_a, upper_b, upper_a, level;
        logic [1:0] mode;
    } disp_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // uva_raw, uvb_raw, comp_one_raw, comp_two_raw, press, wake
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // mode, level, upper_row_a, upper_row_b, lower_row_a, lower_row_b, indicator, sleep
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predicted unit state and register copies
    mode_t       disp_mode = MODE_OFF;
    logic [7:0]  idle_cnt  = 8'd0;
    logic [9:0]  w_a1      = RST_UVA_COMP_ONE;
    logic [9:0]  w_a2      = RST_UVA_COMP_TWO;
    logic [9:0]  w_b1      = RST_UVB_COMP_ONE;
    logic [9:0]  w_b2      = RST_UVB_COMP_TWO;
    logic [15:0] gain_a    = RST_UVA_GAIN;
    logic [15:0] gain_b    = RST_UVB_GAIN;
    logic [7:0]  idle_lim  = RST_IDLE_LIMIT;

    pass_t pending_passes[$];
    disp_t expected_displays[$];
    pass_t offered;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    hold_arm      = 1'b0;
    int    hold_left     = 0;
    int    mismatch_count = 0;
    int    result_index  = 0;
    int    quiet_cycles  = 0;

    uv_index_bar_display_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint unsigned net_light(input logic [15:0] main_raw,
                                                  input logic [15:0] c1,
                                                  input logic [15:0] c2,
                                                  input logic [9:0] wt1,
                                                  input logic [9:0] wt2);
        longint unsigned pos, neg;
        pos = 64'(main_raw) << 8;
        neg = 64'(c1) * 64'(wt1) + 64'(c2) * 64'(wt2);
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic logic [3:0] bar_bits(input logic [7:0] lvl, input int first);
        logic [3:0] bits;
        bits = 4'd0;
        for (int k = 0; k < 4; k++)
            if (int'(lvl) >= first + 32 * k)
                bits[k] = 1'b1;
        return bits;
    endfunction

    // advances the predicted mode state by one pass and returns its display
    function automatic disp_t predict_display(input pass_t p);
        disp_t           r;
        logic [1:0]      next_mode;
        longint unsigned a_calc, b_calc, raw_lvl;
        logic [7:0]      lvl;
        r = '0;
        if (disp_mode == MODE_OFF) begin
            if (p.wake) begin
                disp_mode = MODE_UVI;
                idle_cnt  = 8'd1;
                if (idle_cnt >= idle_lim)
                    disp_mode = MODE_OFF;
            end
        end else begin
            if (p.press != PRESS_NONE) begin
                idle_cnt = 8'd0;
                if (p.press == PRESS_SHORT) begin
                    next_mode = disp_mode + 2'd1;
                    disp_mode = mode_t'(next_mode);
                end
            end
            if (idle_cnt != 8'hFF)
                idle_cnt = idle_cnt + 8'd1;
            if (idle_cnt >= idle_lim)
                disp_mode = MODE_OFF;
        end
        r.mode = disp_mode;
        if (disp_mode == MODE_OFF) begin
            idle_cnt = 8'd0;
            r.sleep  = 1'b1;
            return r;
        end
        a_calc = net_light(p.uva, p.comp_one, p.comp_two, w_a1, w_a2);
        b_calc = net_light(p.uvb, p.comp_one, p.comp_two, w_b1, w_b2);
        case (disp_mode)
            MODE_UVI: raw_lvl = (a_calc * gain_a + b_calc * gain_b) >> 25;
            MODE_UVA: raw_lvl = (a_calc * gain_a) >> 24;
            default:  raw_lvl = (b_calc * gain_b) >> 24;
        endcase
        lvl         = (raw_lvl > 64'(LEVEL_MAX)) ? LEVEL_MAX : raw_lvl[7:0];
        r.level     = lvl;
        r.upper_a   = ROW_A_BASE | {4'd0, bar_bits(lvl, int'(THR_UPPER_A))};
        r.upper_b   = ROW_B_BASE | {4'd0, bar_bits(lvl, int'(THR_UPPER_B))};
        r.lower_a   = ROW_A_BASE | {4'd0, bar_bits(lvl, int'(THR_LOWER_A))};
        r.lower_b   = ROW_B_BASE | {4'd0, bar_bits(lvl, int'(THR_LOWER_B))};
        r.indicator = IND_BASE | (8'd1 << (disp_mode - 1));
        return r;
    endfunction

    function automatic pass_t random_pass();
        pass_t p;
        int    r;
        r = $urandom_range(99);
        p.press = (r < 78) ? PRESS_NONE : (r < 90) ? PRESS_SHORT :
                  (r < 96) ? PRESS_LONG : PRESS_THREE;
        p.wake     = ($urandom_range(3) == 0);
        // spread magnitudes over many octaves so levels land everywhere
        p.uva      = 16'($urandom_range(32'hFFFF >> $urandom_range(12)));
        p.uvb      = 16'($urandom_range(32'hFFFF >> $urandom_range(12)));
        p.comp_one = 16'($urandom_range(32'hFFFF >> $urandom_range(15)));
        p.comp_two = 16'($urandom_range(32'hFFFF >> $urandom_range(15)));
        return p;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_displays.push_back(predict_display(offered));
            if (!s_tvalid || s_tready) begin
                if (pending_passes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_passes.pop_front();
                    s_tdata  <= {{(IN_DATA_W - $bits(pass_t)){1'b0}}, offered};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        disp_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = disp_t'(m_tdata[$bits(disp_t)-1:0]);
                if (expected_displays.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result %0d: %h", result_index, got);
                end else begin
                    want = expected_displays.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("result %0d mismatch: expected mode %0d level %0d rows %h %h %h %h ind %h sleep %b",
                                     result_index, want.mode, want.level, want.upper_a,
                                     want.upper_b, want.lower_a, want.lower_b,
                                     want.indicator, want.sleep);
                            $display("result %0d mismatch: got mode %0d level %0d rows %h %h %h %h ind %h sleep %b",
                                     result_index, got.mode, got.level, got.upper_a,
                                     got.upper_b, got.lower_a, got.lower_b,
                                     got.indicator, got.sleep);
                        end
                    end
                end
                result_index++;
            end
            if (hold_arm) begin
                hold_left = HOLD_CYCLES;
                hold_arm  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_UVA_COMP_ONE: w_a1     = val[9:0];
            REG_UVA_COMP_TWO: w_a2     = val[9:0];
            REG_UVB_COMP_ONE: w_b1     = val[9:0];
            REG_UVB_COMP_TWO: w_b2     = val[9:0];
            REG_UVA_GAIN:     gain_a   = val[15:0];
            REG_UVB_GAIN:     gain_b   = val[15:0];
            REG_IDLE_LIMIT:   idle_lim = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int a1, input int a2, input int b1, input int b2,
                              input int ga, input int gb, input int lim);
        write_cfg(REG_UVA_COMP_ONE, a1);
        write_cfg(REG_UVA_COMP_TWO, a2);
        write_cfg(REG_UVB_COMP_ONE, b1);
        write_cfg(REG_UVB_COMP_TWO, b2);
        write_cfg(REG_UVA_GAIN, ga);
        write_cfg(REG_UVB_GAIN, gb);
        write_cfg(REG_IDLE_LIMIT, lim);
    endtask

    task automatic queue_pass(input logic [15:0] uva, input logic [15:0] uvb,
                              input logic [15:0] c1, input logic [15:0] c2,
                              input logic [1:0] press, input logic wake);
        pass_t p;
        p.uva      = uva;
        p.uvb      = uvb;
        p.comp_one = c1;
        p.comp_two = c2;
        p.press    = press;
        p.wake     = wake;
        pending_passes.push_back(p);
    endtask

    // wait until every queued request is sent and answered, then let the unit settle
    task automatic drain();
        do @(posedge aclk);
        while (pending_passes.size() != 0 || s_tvalid || expected_displays.size() != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) pending_passes.push_back(random_pass());
        drain();
    endtask

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 56;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // off without wake ignores presses
        queue_pass(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS_SHORT, 1'b0);
        queue_pass(16'h0000, 16'h0000, 16'h0000, 16'h0000, PRESS_THREE, 1'b0);
        // wake with a short press only turns on
        queue_pass(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, PRESS_SHORT, 1'b1);
        queue_pass(16'h0000, 16'h0000, 16'h0000, 16'h0000, PRESS_NONE, 1'b1);
        // compensation larger than the reading clamps to zero
        queue_pass(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS_NONE, 1'b0);
        queue_pass(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, PRESS_SHORT, 1'b0);
        queue_pass(16'h0800, 16'h0800, 16'h0010, 16'h0020, PRESS_LONG, 1'b0);
        queue_pass(16'h0400, 16'h0400, 16'h0000, 16'h0000, PRESS_SHORT, 1'b0);
        queue_pass(16'h1000, 16'h1000, 16'h0001, 16'h0001, PRESS_THREE, 1'b1);
        // short press in uvb mode wraps to off
        queue_pass(16'h1234, 16'h4321, 16'h0000, 16'h0000, PRESS_SHORT, 1'b0);
        queue_pass(16'h1234, 16'h4321, 16'h0000, 16'h0000, PRESS_NONE, 1'b0);
        queue_pass(16'h0300, 16'h0500, 16'h0002, 16'h0003, PRESS_NONE, 1'b1);
        drain();

        // timeout on the first pass after wake
        write_cfg(REG_IDLE_LIMIT, 1);
        queue_pass(16'h0300, 16'h0500, 16'h0000, 16'h0000, PRESS_NONE, 1'b1);
        drain();
        write_cfg(REG_IDLE_LIMIT, 0);
        queue_pass(16'h0300, 16'h0500, 16'h0000, 16'h0000, PRESS_SHORT, 1'b1);
        queue_pass(16'h0300, 16'h0500, 16'h0000, 16'h0000, PRESS_NONE, 1'b0);
        drain();
        write_cfg(REG_IDLE_LIMIT, 3);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_NONE, 1'b1);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_NONE, 1'b0);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_NONE, 1'b0);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_NONE, 1'b1);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_LONG, 1'b0);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_NONE, 1'b0);
        queue_pass(16'h0100, 16'h0100, 16'h0000, 16'h0000, PRESS_NONE, 1'b0);
        drain();
        // write to an unused address changes nothing
        write_cfg(REG_SPARE, 32'hFFFF_FFFF);
        queue_pass(16'h0200, 16'h0200, 16'h0000, 16'h0000, PRESS_NONE, 1'b1);
        queue_pass(16'h0200, 16'h0200, 16'h0000, 16'h0000, PRESS_SHORT, 1'b0);
        drain();

        set_config($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(255, 20));
        hold_arm = 1'b1;
        run_random(450);

        // no compensation, full gain: level follows the reading closely
        set_config(0, 0, 0, 0, 65535, 65535, 255);
        run_random(400);

        send_idle_pct = 56;
        recv_idle_pct = 15;
        set_config(1023, 1023, 1023, 1023, $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(12, 2));
        run_random(350);

        set_config($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), 0, 0, 40);
        run_random(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(255, 1));
        run_random(350);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
